[hw/rtl/bhd_pkg.sv]
`timescale 1ns / 1ps

package bhd_pkg;

  // field widths
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DIST_W  = 16;

  // accumulator widths
  localparam int unsigned SUM_W  = 28;
  localparam int unsigned RSUM_W = 36;

  // shared root / divide unit
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned REM_W  = 34;
  localparam int unsigned SH_W   = 64;
  localparam int unsigned MUL_W  = 2 * SUM_W;
  localparam int unsigned STEP_W = 6;

  // step counts: per-bin root of a*b*2^16, denominator root of Sa*Sb*2^6,
  // 32 quotient bits, root of a 33-bit radicand
  localparam logic [STEP_W-1:0] BIN_STEPS  = STEP_W'(24);
  localparam logic [STEP_W-1:0] DEN_STEPS  = STEP_W'(32);
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(32);
  localparam logic [STEP_W-1:0] DIST_STEPS = STEP_W'(17);

  // ratio scale: S * 2^27 / D gives Q.32
  localparam int unsigned RATIO_SHIFT = 27;
  localparam int unsigned DEN_FRAC    = 6;

endpackage

[hw/rtl/bhd_stream_if.sv]
`timescale 1ns / 1ps

// input channel: one bin pair per transfer
interface bhd_in_if;
  logic                          valid;
  logic                          ready;
  logic [bhd_pkg::COUNT_W-1:0]   bin_a;
  logic [bhd_pkg::COUNT_W-1:0]   bin_b;
  logic                          last_bin;

  modport source (output valid, output bin_a, output bin_b, output last_bin, input ready);
  modport sink   (input valid, input bin_a, input bin_b, input last_bin, output ready);
endinterface

// output channel: one distance per histogram pair
interface bhd_out_if;
  logic                          valid;
  logic                          ready;
  logic [bhd_pkg::DIST_W-1:0]    distance;
  logic                          empty_hist;

  modport source (output valid, output distance, output empty_hist, input ready);
  modport sink   (input valid, input distance, input empty_hist, output ready);
endinterface

[hw/rtl/bhattacharyya_histogram_distance.sv]
`timescale 1ns / 1ps

// bhattacharyya distance between two histograms, streamed one bin pair per transfer
//
// in_i  : bin_a, bin_b (unsigned counts) and last_bin; valid/ready handshake
// out_o : distance (unsigned Q0.16, saturating at 65535) and empty_hist,
//         one transfer for each bin pair marked last_bin
//
// every bin pair costs a transfer, 24 steps of the shared root/divide unit
// (one root bit per step) and an accumulate; in_i.ready is low meanwhile. a
// last bin adds a multiply, 32 root steps for sqrt(Sa*Sb), a compare, 32
// quotient steps, 17 root steps for the distance and the finish. an empty
// histogram skips straight to the finish, a coefficient at or above one skips
// the divide and the last root. the shared compare/subtract unit works one bit
// per cycle
//
// the result sits in an output register; the next histogram is taken while it
// waits. if the receiver still stalls when the next result is ready, the block
// holds it and keeps in_i.ready low until the register frees up
//
// reset (rst_ni low, asynchronous) clears all running sums and drops out_o.valid

module bhattacharyya_histogram_distance (
  input  logic          clk_i,
  input  logic          rst_ni,
  bhd_in_if.sink        in_i,
  bhd_out_if.source     out_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT_BIN,
    ST_BIN_END,
    ST_MUL,
    ST_SQRT_DEN,
    ST_CHECK,
    ST_DIV,
    ST_LOAD_DIST,
    ST_SQRT_DIST,
    ST_DIST_END,
    ST_DONE
  } state_e;

  state_e                            state_q, state_d;

  logic [bhd_pkg::SUM_W-1:0]         sa_q, sa_d;
  logic [bhd_pkg::SUM_W-1:0]         sb_q, sb_d;
  logic [bhd_pkg::RSUM_W-1:0]        rs_q, rs_d;
  logic                              last_q, last_d;

  // shared unit registers
  logic [bhd_pkg::SH_W-1:0]          sh_q, sh_d;
  logic [bhd_pkg::REM_W-1:0]         rem_q, rem_d;
  logic [bhd_pkg::ROOT_W-1:0]        acc_q, acc_d;
  logic [bhd_pkg::ROOT_W-1:0]        den_q, den_d;
  logic [bhd_pkg::STEP_W-1:0]        cnt_q, cnt_d;

  // result and output register
  logic [bhd_pkg::DIST_W-1:0]        res_dist_q, res_dist_d;
  logic                              res_empty_q, res_empty_d;
  logic                              out_valid_q, out_valid_d;
  logic [bhd_pkg::DIST_W-1:0]        out_dist_q, out_dist_d;
  logic                              out_empty_q, out_empty_d;

  // shared multiplier: a*b on a transfer, Sa*Sb on the last bin
  logic [bhd_pkg::SUM_W-1:0]         mul_x, mul_y;
  logic [bhd_pkg::MUL_W-1:0]         prod;

  // shared compare/subtract unit
  logic [35:0]                       unit_x, unit_y;
  logic [36:0]                       unit_diff;
  logic                              unit_ge;
  logic [bhd_pkg::REM_W-1:0]         unit_rem;
  logic [bhd_pkg::ROOT_W-1:0]        unit_acc;
  logic [bhd_pkg::SH_W-1:0]          unit_sh;
  logic                              unit_last;

  logic                              in_xfer;
  logic                              out_xfer;
  logic                              out_free;
  logic [32:0]                       dist_rad;
  logic [bhd_pkg::RSUM_W:0]          den_scaled;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_valid_q && out_o.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.distance   = out_dist_q;
  assign out_o.empty_hist = out_empty_q;

  always_comb begin
    if (state_q == ST_IDLE) begin
      mul_x = bhd_pkg::SUM_W'(in_i.bin_a);
      mul_y = bhd_pkg::SUM_W'(in_i.bin_b);
    end else begin
      mul_x = sa_q;
      mul_y = sb_q;
    end
    prod = bhd_pkg::MUL_W'(mul_x) * bhd_pkg::MUL_W'(mul_y);
  end

  // one step: a root takes two radicand bits, a quotient one dividend bit
  always_comb begin
    if (state_q == ST_DIV) begin
      unit_x  = {1'b0, rem_q, sh_q[bhd_pkg::SH_W-1]};
      unit_y  = {4'b0, den_q};
      unit_sh = sh_q << 1;
    end else begin
      unit_x  = {rem_q, sh_q[bhd_pkg::SH_W-1 -: 2]};
      unit_y  = {2'b0, acc_q, 2'b01};
      unit_sh = sh_q << 2;
    end
    unit_diff = {1'b0, unit_x} - {1'b0, unit_y};
    unit_ge   = !unit_diff[36];
    unit_rem  = unit_ge ? unit_diff[bhd_pkg::REM_W-1:0] : unit_x[bhd_pkg::REM_W-1:0];
    unit_acc  = {acc_q[bhd_pkg::ROOT_W-2:0], unit_ge};
    unit_last = (cnt_q == bhd_pkg::STEP_W'(1));
  end

  // radicand 2^32 - ratio; ratio is below 2^32 here
  assign dist_rad   = {1'b1, 32'b0} - {1'b0, acc_q};
  assign den_scaled = {acc_q, 5'b0};

  always_comb begin
    state_d     = state_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    rs_d        = rs_q;
    last_d      = last_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    res_dist_d  = res_dist_q;
    res_empty_d = res_empty_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_dist_d  = out_dist_q;
    out_empty_d = out_empty_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          sa_d    = sa_q + bhd_pkg::SUM_W'(in_i.bin_a);
          sb_d    = sb_q + bhd_pkg::SUM_W'(in_i.bin_b);
          last_d  = in_i.last_bin;
          // radicand a*b*2^16, left-aligned for 24 root steps
          sh_d    = {prod[31:0], 32'b0};
          rem_d   = '0;
          acc_d   = '0;
          cnt_d   = bhd_pkg::BIN_STEPS;
          state_d = ST_SQRT_BIN;
        end
      end
      ST_SQRT_BIN, ST_SQRT_DEN, ST_DIV, ST_SQRT_DIST: begin
        sh_d  = unit_sh;
        rem_d = unit_rem;
        acc_d = unit_acc;
        cnt_d = cnt_q - bhd_pkg::STEP_W'(1);
        if (unit_last) begin
          case (state_q)
            ST_SQRT_BIN: state_d = ST_BIN_END;
            ST_SQRT_DEN: state_d = ST_CHECK;
            ST_DIV:      state_d = ST_LOAD_DIST;
            default:     state_d = ST_DIST_END;
          endcase
        end
      end
      ST_BIN_END: begin
        rs_d = rs_q + bhd_pkg::RSUM_W'(acc_q);
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (sa_q == '0 || sb_q == '0) begin
          // empty histogram
          res_dist_d  = '0;
          res_empty_d = 1'b1;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // radicand Sa*Sb*2^6 for the denominator root
        sh_d    = {2'b0, prod, bhd_pkg::DEN_FRAC'(0)};
        rem_d   = '0;
        acc_d   = '0;
        cnt_d   = bhd_pkg::DEN_STEPS;
        state_d = ST_SQRT_DEN;
      end
      ST_CHECK: begin
        den_d       = acc_q;
        res_empty_d = 1'b0;
        if ({1'b0, rs_q} >= den_scaled) begin
          // coefficient at or above one
          res_dist_d = '0;
          state_d    = ST_DONE;
        end else begin
          // dividend S*2^27: top part seeds the remainder
          rem_d   = bhd_pkg::REM_W'(rs_q[bhd_pkg::RSUM_W-1:5]);
          sh_d    = {rs_q[4:0], 59'b0};
          acc_d   = '0;
          cnt_d   = bhd_pkg::DIV_STEPS;
          state_d = ST_DIV;
        end
      end
      ST_LOAD_DIST: begin
        sh_d    = {1'b0, dist_rad, 30'b0};
        rem_d   = '0;
        acc_d   = '0;
        cnt_d   = bhd_pkg::DIST_STEPS;
        state_d = ST_SQRT_DIST;
      end
      ST_DIST_END: begin
        // a distance of exactly one saturates
        res_dist_d = acc_q[bhd_pkg::DIST_W] ? '1 : acc_q[bhd_pkg::DIST_W-1:0];
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dist_d  = res_dist_q;
          out_empty_d = res_empty_q;
          sa_d        = '0;
          sb_d        = '0;
          rs_d        = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sa_q        <= '0;
      sb_q        <= '0;
      rs_q        <= '0;
      last_q      <= 1'b0;
      sh_q        <= '0;
      rem_q       <= '0;
      acc_q       <= '0;
      den_q       <= '0;
      cnt_q       <= '0;
      res_dist_q  <= '0;
      res_empty_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_dist_q  <= '0;
      out_empty_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sa_q        <= sa_d;
      sb_q        <= sb_d;
      rs_q        <= rs_d;
      last_q      <= last_d;
      sh_q        <= sh_d;
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      den_q       <= den_d;
      cnt_q       <= cnt_d;
      res_dist_q  <= res_dist_d;
      res_empty_q <= res_empty_d;
      out_valid_q <= out_valid_d;
      out_dist_q  <= out_dist_d;
      out_empty_q <= out_empty_d;
    end
  end

`ifndef ASSERT_OFF
  // a transfer always starts the per-bin root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_SQRT_BIN && cnt_q == bhd_pkg::BIN_STEPS))
    else $error("bin transfer did not start the root unit");

  // the shared unit never runs with an exhausted step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT_BIN || state_q == ST_SQRT_DEN || state_q == ST_DIV ||
     state_q == ST_SQRT_DIST) |-> (cnt_q != '0))
    else $error("shared unit running with zero step count");

  // an empty histogram always reports distance zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.empty_hist) |-> (out_o.distance == '0))
    else $error("empty histogram with non-zero distance");

  // sums are clear whenever a new result has just been loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (sa_q == '0 && sb_q == '0 && rs_q == '0))
    else $error("accumulators not cleared after a result");
`endif

endmodule

[dv/bhd_distance_checker.sv]
`timescale 1ns / 1ps

module bhd_distance_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [bhd_pkg::COUNT_W-1:0] in_bin_a_i,
  input  logic [bhd_pkg::COUNT_W-1:0] in_bin_b_i,
  input  logic                        in_last_bin_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [bhd_pkg::DIST_W-1:0]  out_distance_i,
  input  logic                        out_empty_hist_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 pending_o
);

  typedef struct packed {
    logic [bhd_pkg::DIST_W-1:0] distance;
    logic                       empty_hist;
  } hist_distance_t;

  hist_distance_t             expected_distances[$];
  logic [bhd_pkg::SUM_W-1:0]  first_total  = '0;
  logic [bhd_pkg::SUM_W-1:0]  second_total = '0;
  logic [bhd_pkg::RSUM_W-1:0] root_total   = '0;
  int unsigned                mismatches   = 0;

  // floor of the square root, built one result bit at a time from the top
  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // fold one bin pair into the running sums; a last bin yields the distance
  task automatic absorb_bin(input logic [bhd_pkg::COUNT_W-1:0] a,
                            input logic [bhd_pkg::COUNT_W-1:0] b,
                            input logic last);
    logic [63:0]    denom;
    logic [63:0]    ratio;
    logic [63:0]    radicand;
    logic [63:0]    root;
    hist_distance_t res;
    first_total  = first_total + bhd_pkg::SUM_W'(a);
    second_total = second_total + bhd_pkg::SUM_W'(b);
    root_total   = root_total + bhd_pkg::RSUM_W'(floor_root((64'(a) * 64'(b)) << 16));
    if (last) begin
      if (first_total == '0 || second_total == '0) begin
        res.distance   = '0;
        res.empty_hist = 1'b1;
      end else begin
        denom    = floor_root((64'(first_total) * 64'(second_total)) << bhd_pkg::DEN_FRAC);
        ratio    = (64'(root_total) << bhd_pkg::RATIO_SHIFT) / denom;
        radicand = (ratio < (64'd1 << 32)) ? ((64'd1 << 32) - ratio) : 64'd0;
        root     = floor_root(radicand);
        res.distance   = (root > 64'hFFFF) ? '1 : bhd_pkg::DIST_W'(root);
        res.empty_hist = 1'b0;
      end
      expected_distances = {expected_distances, res};
      first_total  = '0;
      second_total = '0;
      root_total   = '0;
    end
  endtask

  always @(posedge clk_i) begin : watch
    hist_distance_t want;
    if (rst_ni) begin
      // results first: an input taken at this edge cannot leave at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_distances.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected: distance %0d empty_hist %0d",
                   $time, out_distance_i, out_empty_hist_i);
        end else begin
          want = expected_distances.pop_front();
          if (out_distance_i !== want.distance) begin
            mismatches++;
            $display("%0t: distance expected %0d actual %0d",
                     $time, want.distance, out_distance_i);
          end
          if (out_empty_hist_i !== want.empty_hist) begin
            mismatches++;
            $display("%0t: empty_hist expected %0d actual %0d",
                     $time, want.empty_hist, out_empty_hist_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_bin(in_bin_a_i, in_bin_b_i, in_last_bin_i);
    end
    mismatch_count_o <= mismatches;
    pending_o        <= $unsigned(expected_distances.size());
  end

endmodule

[dv/bhattacharyya_histogram_distance_test.sv]
`timescale 1ns / 1ps

module bhattacharyya_histogram_distance_test;

  // bin pairs in the random part
  localparam int unsigned RANDOM_BINS  = 1300;
  // identical full-scale bins in one histogram pair, coefficient at one over many bins
  localparam int unsigned FULL_BINS    = 16;
  // cycles with no transfer on either channel before the run is abandoned;
  // the slowest correct gap is one bin plus the final pass plus both idle draws
  localparam int unsigned STALL_LIMIT  = 2000;
  // settle time after the last expected result, well past the final-pass latency
  localparam int unsigned DRAIN_CYCLES = 200;

  // shapes of histogram pairs for the random part
  typedef enum logic [2:0] {
    HIST_WIDE,
    HIST_SMALL,
    HIST_ALIKE,
    HIST_SPARSE,
    HIST_ONE_EMPTY,
    HIST_DISJOINT,
    HIST_FULL
  } hist_kind_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned bins_sent;
  int unsigned in_calm_left;
  int unsigned out_calm_left;

  bhd_in_if  in_ch ();
  bhd_out_if out_ch ();

  bhattacharyya_histogram_distance DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // checker watches both channels, predicts each distance and counts mismatches
  bhd_distance_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .in_bin_a_i       (in_ch.bin_a),
    .in_bin_b_i       (in_ch.bin_b),
    .in_last_bin_i    (in_ch.last_bin),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_distance_i   (out_ch.distance),
    .out_empty_hist_i (out_ch.empty_hist),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // idle cycles before the next transfer: mostly a uniform draw, with calm stretches of none
  function automatic int unsigned pick_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(11, 0) == 0) begin
      calm_left = $urandom_range(40, 5);
      return 0;
    end
    return $urandom_range(13, 0);
  endfunction

  // offer one bin pair and hold it until the transfer; returns at the accepting edge.
  // valid is only lowered when a gap follows, so it never drops and rises in one step
  task automatic send_bin(input logic [bhd_pkg::COUNT_W-1:0] a,
                          input logic [bhd_pkg::COUNT_W-1:0] b,
                          input logic last);
    int unsigned gap;
    gap = pick_wait(in_calm_left);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.bin_a    <= a;
    in_ch.bin_b    <= b;
    in_ch.last_bin <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bins_sent++;
  endtask

  // one histogram pair of the given shape, last_bin on the final pair
  task automatic send_histogram(input int unsigned nbins, input hist_kind_e kind);
    logic [bhd_pkg::COUNT_W-1:0] a;
    logic [bhd_pkg::COUNT_W-1:0] b;
    int                          near;
    logic                        first_empty;
    first_empty = 1'($urandom_range(1, 0));
    for (int unsigned i = 0; i < nbins; i++) begin
      case (kind)
        HIST_WIDE: begin
          a = bhd_pkg::COUNT_W'($urandom);
          b = bhd_pkg::COUNT_W'($urandom);
        end
        HIST_SMALL: begin
          a = bhd_pkg::COUNT_W'($urandom_range(15, 0));
          b = bhd_pkg::COUNT_W'($urandom_range(15, 0));
        end
        HIST_ALIKE: begin
          // nearly identical counts drive the coefficient close to one
          a    = bhd_pkg::COUNT_W'($urandom);
          near = int'(a) + int'($urandom_range(8, 0)) - 4;
          if (near < 0) near = 0;
          if (near > 65535) near = 65535;
          b = bhd_pkg::COUNT_W'(near);
        end
        HIST_SPARSE: begin
          a = ($urandom_range(2, 0) == 0) ? bhd_pkg::COUNT_W'($urandom) : '0;
          b = ($urandom_range(2, 0) == 0) ? bhd_pkg::COUNT_W'($urandom) : '0;
        end
        HIST_ONE_EMPTY: begin
          // one side all zero, so the empty flag is raised
          a = first_empty ? '0 : bhd_pkg::COUNT_W'($urandom);
          b = first_empty ? bhd_pkg::COUNT_W'($urandom) : '0;
        end
        HIST_DISJOINT: begin
          // no overlap at all, so the distance saturates
          a = i[0] ? bhd_pkg::COUNT_W'($urandom) : '0;
          b = i[0] ? '0 : bhd_pkg::COUNT_W'($urandom);
        end
        default: begin
          a = '1;
          b = '1;
        end
      endcase
      send_bin(a, b, i == nbins - 1);
    end
  endtask

  // receiver: stalls a drawn number of cycles before each result transfer
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = pick_wait(out_calm_left);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // watchdog: a long stretch with no transfer on either channel means a hang
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[bhattacharyya_histogram_distance] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_start;
    int unsigned nbins;
    int unsigned pick;
    hist_kind_e  kind;

    bins_sent     = 0;
    in_calm_left  = 0;
    out_calm_left = 0;
    rst_ni        = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.bin_a    <= '0;
    in_ch.bin_b    <= '0;
    in_ch.last_bin <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty histograms, on both sides and on either side alone
    send_bin(16'h0000, 16'h0000, 1'b1);
    send_bin(16'h0005, 16'h0000, 1'b1);
    send_bin(16'h0000, 16'h0007, 1'b1);
    // identical full-scale bins, coefficient at or just about one
    send_bin(16'hFFFF, 16'hFFFF, 1'b1);
    // disjoint bins, distance of one saturates
    send_bin(16'd100, 16'h0000, 1'b0);
    send_bin(16'h0000, 16'd100, 1'b1);
    // smallest non-empty pair
    send_bin(16'h0001, 16'h0001, 1'b1);
    // extreme imbalance between the two counts
    send_bin(16'hFFFF, 16'h0001, 1'b1);
    send_bin(16'h0001, 16'hFFFF, 1'b1);
    // identical multi-bin histograms across the count range
    send_bin(16'h0003, 16'h0003, 1'b0);
    send_bin(16'd1000, 16'd1000, 1'b0);
    send_bin(16'hFFFF, 16'hFFFF, 1'b1);
    // alternating bit patterns on both counts
    send_bin(16'hAAAA, 16'h5555, 1'b0);
    send_bin(16'h5555, 16'hAAAA, 1'b1);

    // many identical full-scale bins in one pair
    send_histogram(FULL_BINS, HIST_FULL);

    // random histogram pairs, mostly short, a few long
    random_start = bins_sent;
    while (bins_sent - random_start < RANDOM_BINS) begin
      pick = $urandom_range(99, 0);
      if (pick < 70) nbins = $urandom_range(8, 1);
      else if (pick < 95) nbins = $urandom_range(40, 9);
      else nbins = $urandom_range(300, 41);
      pick = $urandom_range(9, 0);
      case (pick)
        0, 1, 2: kind = HIST_WIDE;
        3:       kind = HIST_SMALL;
        4, 5, 6: kind = HIST_ALIKE;
        7:       kind = HIST_SPARSE;
        8:       kind = HIST_ONE_EMPTY;
        default: kind = HIST_DISJOINT;
      endcase
      send_histogram(nbins, kind);
    end
    in_ch.valid <= 1'b0;

    // let the checker's count catch up, then wait for every distance to arrive
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[bhattacharyya_histogram_distance] OK");
    end else begin
      $display("[bhattacharyya_histogram_distance] ERROR");
    end
    $finish;
  end

endmodule
